// ===== src/ldpi_pkg.sv =====
// shared types and constants for the dual-path lms identifier
package ldpi_pkg;

   localparam int FilterOrder = 40;
   localparam int NumTaps = FilterOrder + 1;
   localparam int TapW = $clog2(NumTaps);
   localparam int IdxW = 6;
   localparam int CoefW = 24;
   localparam int AccW = 48;

   localparam logic signed [CoefW-1:0] CoefMax = 24'sh7FFFFF;
   localparam logic signed [CoefW-1:0] CoefMin = -24'sh800000;

   localparam logic [23:0] StepReset = 24'd168;
   localparam logic [14:0] LevelReset = 15'd8192;
   localparam logic [16:0] LimitReset = 17'd50000;
   localparam logic [15:0] LfsrReset = 16'hFFFF;

   localparam logic [1:0] RegStep = 2'd0;
   localparam logic [1:0] RegLevel = 2'd1;
   localparam logic [1:0] RegLimit = 2'd2;

   typedef struct packed {
      logic signed [15:0] ref_sample;
      logic signed [15:0] err_sample;
      logic [IdxW-1:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] dac_sample;
      logic signed [15:0] forward_error;
      logic signed [15:0] inverse_error;
      logic identified;
      logic signed [CoefW-1:0] forward_coef;
      logic signed [CoefW-1:0] inverse_coef;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILT, ST_ERR, ST_SCALE, ST_MULT, ST_UPD, ST_WB, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic clear_acc;
      logic mac_en;
      logic err_en;
      logic scale_en;
      logic upd_en;
      logic finish;
      logic [TapW-1:0] tap;
   } cmd_type;

endpackage

// ===== src/ldpi_ctrl.sv =====
// sequencer for the filter, error, scale and update passes
module ldpi_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic out_busy,
   output ldpi_pkg::cmd_type cmd
);
   ldpi_pkg::state_type state_ff, state_in;
   logic [ldpi_pkg::TapW-1:0] tap_ff, tap_in;
   localparam logic [ldpi_pkg::TapW-1:0] Last = ldpi_pkg::TapW'(ldpi_pkg::NumTaps - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldpi_pkg::ST_IDLE;
         tap_ff <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff <= tap_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      tap_in = tap_ff;
      cmd = '0;
      cmd.tap = tap_ff;
      req_ready = 1'b0;
      case (state_ff)
         ldpi_pkg::ST_IDLE: begin
            req_ready = !out_busy;
            if (req_valid && !out_busy) begin
               cmd.start = 1'b1;
               cmd.clear_acc = 1'b1;
               tap_in = '0;
               state_in = ldpi_pkg::ST_FILT;
            end
         end
         ldpi_pkg::ST_FILT: begin
            cmd.mac_en = 1'b1;
            if (tap_ff == Last) begin
               tap_in = '0;
               state_in = ldpi_pkg::ST_ERR;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ldpi_pkg::ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in = ldpi_pkg::ST_SCALE;
         end
         ldpi_pkg::ST_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in = ldpi_pkg::ST_MULT;
         end
         ldpi_pkg::ST_MULT: begin
            state_in = ldpi_pkg::ST_UPD;
         end
         ldpi_pkg::ST_UPD: begin
            cmd.upd_en = 1'b1;
            if (tap_ff == Last) begin
               tap_in = '0;
               state_in = ldpi_pkg::ST_WB;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ldpi_pkg::ST_WB: begin
            state_in = ldpi_pkg::ST_DONE;
         end
         ldpi_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ldpi_pkg::ST_IDLE;
         end
         default: state_in = ldpi_pkg::ST_IDLE;
      endcase
   end
endmodule

// ===== src/ldpi_datapath.sv =====
// probe generator, tap history, coefficient stores and mac datapath
module ldpi_datapath (
   input  logic clock,
   input  logic reset,
   input  ldpi_pkg::cmd_type cmd,
   input  ldpi_pkg::req_word_type req_word,
   input  logic [23:0] step_size,
   input  logic [14:0] probe_level,
   input  logic [16:0] sample_limit,
   output ldpi_pkg::rsp_word_type result
);
   localparam int TapW = ldpi_pkg::TapW;
   localparam int AccW = ldpi_pkg::AccW;
   localparam int CoefW = ldpi_pkg::CoefW;

   logic [15:0] lfsr_ff;
   logic [ldpi_pkg::NumTaps-1:0] hist_ff;
   logic [16:0] count_ff;
   logic done_ff;
   ldpi_pkg::req_word_type in_ff;
   logic signed [AccW-1:0] facc_ff, iacc_ff;
   logic signed [15:0] fe_ff, ie_ff;
   logic [54:0] ft_ff, it_ff;
   logic [ldpi_pkg::NumTaps-1:0] wr_valid_ff;
   logic signed [CoefW-1:0] fmem [ldpi_pkg::NumTaps];
   logic signed [CoefW-1:0] imem [ldpi_pkg::NumTaps];
   logic signed [CoefW-1:0] frd_ff, ird_ff;
   logic signed [CoefW-1:0] fc_ff, ic_ff;
   logic fneg_ff, ineg_ff;

   // coefficient reads: one per tap, valid bits for reset-to-zero
   logic [TapW-1:0] rd_tap;
   logic [TapW-1:0] pre_tap;
   assign pre_tap = cmd.tap;
   logic signed [CoefW-1:0] fcur, icur;
   logic cur_neg;
   logic [TapW-1:0] cur_tap_ff;
   logic cur_ok_ff;
   assign rd_tap = pre_tap;

   // registered read, used in the cycle after the tap command
   logic mac_d_ff, upd_d_ff;

   always_ff @(posedge clock) begin
      frd_ff <= fmem[rd_tap];
      ird_ff <= imem[rd_tap];
      cur_tap_ff <= rd_tap;
      cur_ok_ff <= wr_valid_ff[rd_tap];
   end

   always_comb begin
      fcur = cur_ok_ff ? frd_ff : '0;
      icur = cur_ok_ff ? ird_ff : '0;
      cur_neg = hist_ff[cur_tap_ff];
   end

   // products with probe level
   logic signed [39:0] fp, ip;
   assign fp = 40'(fcur) * $signed({1'b0, probe_level});
   assign ip = 40'(icur) * $signed({1'b0, probe_level});

   function automatic logic signed [15:0] err_of(input logic signed [15:0] s,
                                                 input logic signed [AccW-1:0] acc);
      logic signed [AccW+1:0] v;
      logic signed [AccW+1:0] q;
      begin
         v = ((AccW+2)'(s) <<< 22) - (AccW+2)'(acc) + (AccW+2)'(2097152);
         q = v >>> 22;
         if (q > 32767) err_of = 16'sh7FFF;
         else if (q < -32768) err_of = -16'sh8000;
         else err_of = q[15:0];
      end
   endfunction

   function automatic logic signed [CoefW-1:0] upd_of(input logic signed [CoefW-1:0] c,
                                                      input logic [54:0] t,
                                                      input logic neg);
      logic signed [57:0] d;
      logic signed [25:0] dq;
      logic signed [26:0] s;
      begin
         d = neg ? -$signed({3'b0, t}) : $signed({3'b0, t});
         d = d + 58'sd2147483648;
         dq = 26'(d >>> 32);
         s = 27'(c) + 27'(dq);
         if (s > 27'(ldpi_pkg::CoefMax)) upd_of = ldpi_pkg::CoefMax;
         else if (s < 27'(ldpi_pkg::CoefMin)) upd_of = ldpi_pkg::CoefMin;
         else upd_of = s[CoefW-1:0];
      end
   endfunction

   logic [16:0] fe_mag, ie_mag;
   assign fe_mag = fe_ff[15] ? 17'(-18'(fe_ff)) : 17'(fe_ff);
   assign ie_mag = ie_ff[15] ? 17'(-18'(ie_ff)) : 17'(ie_ff);
   logic [40:0] fsm_ff, ism_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_d_ff <= 1'b0;
         upd_d_ff <= 1'b0;
      end else begin
         mac_d_ff <= cmd.mac_en;
         upd_d_ff <= cmd.upd_en;
      end
   end

   logic err_d_ff, err_d2_ff, err_d3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         err_d_ff <= 1'b0;
         err_d2_ff <= 1'b0;
         err_d3_ff <= 1'b0;
      end else begin
         err_d_ff <= cmd.err_en;
         err_d2_ff <= cmd.scale_en;
         err_d3_ff <= err_d2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= ldpi_pkg::LfsrReset;
         hist_ff <= '0;
         count_ff <= '0;
         done_ff <= 1'b0;
         wr_valid_ff <= '0;
      end else begin
         if (cmd.start) begin
            hist_ff[0] <= lfsr_ff[0];
            lfsr_ff <= {lfsr_ff[14:0],
                        lfsr_ff[0] ^ lfsr_ff[1] ^ lfsr_ff[11] ^ lfsr_ff[13]};
         end
         if (upd_d_ff) wr_valid_ff[cur_tap_ff] <= 1'b1;
         if (cmd.finish) begin
            hist_ff <= {hist_ff[ldpi_pkg::NumTaps-2:0], 1'b0};
            if (17'(count_ff + 1'b1) >= sample_limit) begin
               count_ff <= '0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) in_ff <= req_word;
      if (cmd.clear_acc) begin
         facc_ff <= '0;
         iacc_ff <= '0;
      end else if (mac_d_ff) begin
         facc_ff <= cur_neg ? facc_ff - AccW'(fp) : facc_ff + AccW'(fp);
         iacc_ff <= cur_neg ? iacc_ff - AccW'(ip) : iacc_ff + AccW'(ip);
      end
      if (err_d_ff) begin
         fe_ff <= err_of(in_ff.err_sample, facc_ff);
         ie_ff <= err_of(in_ff.ref_sample, iacc_ff);
      end
      if (err_d2_ff) begin
         fsm_ff <= 41'(fe_mag) * 41'(step_size);
         ism_ff <= 41'(ie_mag) * 41'(step_size);
      end
      if (err_d3_ff) begin
         ft_ff <= 55'({fsm_ff, 1'b0}) * 55'(probe_level);
         it_ff <= 55'({ism_ff, 1'b0}) * 55'(probe_level);
         fneg_ff <= fe_ff[15];
         ineg_ff <= ie_ff[15];
      end
      if (upd_d_ff) begin
         fmem[cur_tap_ff] <= upd_of(fcur, ft_ff, fneg_ff ^ cur_neg);
         imem[cur_tap_ff] <= upd_of(icur, it_ff, ineg_ff ^ cur_neg);
         if (6'(cur_tap_ff) == in_ff.read_index) begin
            fc_ff <= upd_of(fcur, ft_ff, fneg_ff ^ cur_neg);
            ic_ff <= upd_of(icur, it_ff, ineg_ff ^ cur_neg);
         end
      end
      if (cmd.start) begin
         fc_ff <= '0;
         ic_ff <= '0;
      end
   end

   always_comb begin
      result.dac_sample = hist_ff[0] ? -$signed({1'b0, probe_level})
                                     : $signed({1'b0, probe_level});
      result.forward_error = fe_ff;
      result.inverse_error = ie_ff;
      result.identified = done_ff | (17'(count_ff + 1'b1) >= sample_limit);
      result.forward_coef = fc_ff;
      result.inverse_coef = ic_ff;
   end
endmodule

// ===== src/lms_dual_path_identifier_top.sv =====
// top level: csr port, sequencer, datapath and result register
//  channel | ports          | role
//  req     | req_*          | one word per audio sample
//  rsp     | rsp_*          | one word per accepted sample
//  csr     | csr_p*         | apb writes and reads of three registers
// a word's result is valid after the filter, error, scale, multiply,
// update, write-back and done states, one mac per tap in the filter and
// update passes; the next word waits until the last result is taken.
// reset is synchronous and clears state and coefficients; a stalled
// result holds the block in idle.
module lms_dual_path_identifier_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ldpi_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ldpi_pkg::rsp_word_type rsp_word,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [23:0] step_ff;
   logic [14:0] level_ff;
   logic [16:0] limit_ff;
   logic rsp_valid_ff;
   ldpi_pkg::rsp_word_type rsp_ff, result;
   ldpi_pkg::cmd_type cmd;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ldpi_pkg::StepReset;
         level_ff <= ldpi_pkg::LevelReset;
         limit_ff <= ldpi_pkg::LimitReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            ldpi_pkg::RegStep: step_ff <= csr_pwdata[23:0];
            ldpi_pkg::RegLevel: level_ff <= csr_pwdata[14:0];
            ldpi_pkg::RegLimit: limit_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ldpi_pkg::RegStep: csr_prdata = {8'd0, step_ff};
         ldpi_pkg::RegLevel: csr_prdata = {17'd0, level_ff};
         ldpi_pkg::RegLimit: csr_prdata = {15'd0, limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   ldpi_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .out_busy(rsp_valid_ff), .cmd(cmd)
   );

   ldpi_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word),
      .step_size(step_ff), .probe_level(level_ff), .sample_limit(limit_ff),
      .result(result)
   );

   // result captured as the finish command is issued, before history shifts
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
endmodule
